// ===== hw/rtl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants for the sliding-window LZ text compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam logic [7:0] MARK_BYTE  = 8'hFE;
  localparam logic [7:0] JUMP_BASE  = 8'hF0;
  localparam int         MIN_MATCH  = 4;
  localparam int         DIST_DIV   = 254;
  localparam int         LEN_W      = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/lzw_in_if.sv =====
// ----------------------------------------------------------------------------
// lzw_in_if
// Request channel carrying uncompressed bytes into the compressor.
// ----------------------------------------------------------------------------
interface lzw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/lzw_out_if.sv =====
// ----------------------------------------------------------------------------
// lzw_out_if
// Request channel carrying compressed bytes out of the compressor.
// ----------------------------------------------------------------------------
interface lzw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] total_length;

  modport source (output valid, output out_byte, output out_last, output total_length,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input total_length,
                  output ready);
endinterface

// ===== hw/rtl/lzw_ram.sv =====
// ----------------------------------------------------------------------------
// lzw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/lz_window_text_compressor_core.sv =====
// ----------------------------------------------------------------------------
// lz_window_text_compressor_core
// Greedy LZ compressor searching its own emitted output for matches.
// ----------------------------------------------------------------------------
// Timing: a request is taken only in the idle state; each head decision runs a
// needle scan (one lookahead read per byte), a window scan (one history read
// per compare), distance mapping by repeated subtraction, and then emits its
// bytes while the output is free.
// Throughput: one input request at a time; the history RAM read port sets the
// search rate. Reset clears FSM, fill, pointers, counts and flags; not RAM or search registers.
module lz_window_text_compressor_core #(
  parameter int WINDOW        = 3792,
  parameter int LOOKAHEAD     = 35,
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzw_in_if.sink    in_i,
  lzw_out_if.source out_o
);
  import lzw_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int FW1  = FW + 1;
  localparam int LAW  = $clog2(LOOKAHEAD);
  localparam int LCW  = $clog2(LOOKAHEAD + 1);
  localparam int DW   = (FW > 9) ? FW : 9;
  localparam int WLIM = (WINDOW < HISTORY_DEPTH) ? WINDOW : HISTORY_DEPTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_NRD   = 4'd2;
  localparam logic [3:0] S_NCMP  = 4'd3;
  localparam logic [3:0] S_SETUP = 4'd4;
  localparam logic [3:0] S_HRD   = 4'd5;
  localparam logic [3:0] S_HCMP  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [LAW-1:0]   head_q, head_d;
  logic [LCW-1:0]   cnt_q, cnt_d;
  logic [LCW-1:0]   marks_q, marks_d;
  logic [LEN_W-1:0] emitted_q, emitted_d;
  logic             last_q, last_d;
  logic [7:0]       h_q, h_d;
  logic [LCW-1:0]   n_q, n_d;
  logic [LCW-1:0]   maxl_q, maxl_d;
  logic [LCW-1:0]   i_q, i_d;
  logic [LCW-1:0]   best_q, best_d;
  logic [FW-1:0]    p_q, p_d;
  logic [FW-1:0]    bestp_q, bestp_d;
  logic [AW-1:0]    hp_q, hp_d;
  logic [AW-1:0]    ha_q, ha_d;
  logic [LAW-1:0]   lp_q, lp_d;
  logic [DW-1:0]    rm_q, rm_d;
  logic [4:0]       qt_q, qt_d;
  logic [1:0]       k_q, k_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q, ol_d;
  logic [LEN_W-1:0] tl_q, tl_d;

  logic             la_we;
  logic [LAW-1:0]   la_waddr;
  logic [7:0]       la_rd;
  logic             hs_we;
  logic [7:0]       hs_wdata;
  logic [7:0]       hs_rd;

  logic             in_acc;
  logic [LCW:0]     la_wsum;
  logic [AW:0]      base_sum;
  logic [AW-1:0]    base;

  function automatic logic [AW-1:0] hinc(input logic [AW-1:0] a);
    return (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [LAW-1:0] linc(input logic [LAW-1:0] a);
    return (a == LAW'(LOOKAHEAD - 1)) ? '0 : a + LAW'(1);
  endfunction

  function automatic logic i1_eq_cnt(input logic [LCW-1:0] n, input logic [LCW-1:0] c);
    return (n + LCW'(1)) == c;
  endfunction

  function automatic logic [LAW-1:0] hadd(input logic [LAW-1:0] h, input logic [LCW-1:0] d);
    logic [LCW:0] s;
    s = (LCW+1)'(h) + (LCW+1)'(d);
    return (s >= (LCW+1)'(LOOKAHEAD)) ? LAW'(s - (LCW+1)'(LOOKAHEAD)) : LAW'(s);
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Write slot for a new byte: head plus count, wrapped around the buffer.
  assign la_wsum  = (LCW+1)'(head_q) + (LCW+1)'(cnt_q);
  assign la_waddr = (la_wsum >= (LCW+1)'(LOOKAHEAD)) ?
                    LAW'(la_wsum - (LCW+1)'(LOOKAHEAD)) : LAW'(la_wsum);
  assign la_we    = in_acc && (cnt_q < LCW'(LOOKAHEAD));

  // Oldest byte of the active window.
  assign base_sum = (AW+1)'(wp_q) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(fill_q);
  assign base     = (base_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                    AW'(base_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(base_sum);

  lzw_ram #(.Depth(LOOKAHEAD), .Width(8)) u_la_ram (
    .clk_i  (clk_i),
    .we_i   (la_we),
    .waddr_i(la_waddr),
    .wdata_i(in_i.in_byte),
    .raddr_i(lp_q),
    .rdata_o(la_rd)
  );

  lzw_ram #(.Depth(HISTORY_DEPTH), .Width(8)) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hs_we),
    .waddr_i(wp_q),
    .wdata_i(hs_wdata),
    .raddr_i(ha_q),
    .rdata_o(hs_rd)
  );

  always_comb begin
    logic [LCW-1:0] i1;
    logic           eq;
    logic           cont;
    logic [LCW-1:0] m;
    logic [LCW-1:0] nb;
    logic [FW-1:0]  ml;
    logic [7:0]     l8;
    logic           is_match;
    logic           final_b;
    logic [LCW-1:0] drop;
    logic [LEN_W-1:0] em1;

    state_d = state_q;  fill_d = fill_q;   wp_d = wp_q;       head_d = head_q;
    cnt_d = cnt_q;      marks_d = marks_q; emitted_d = emitted_q;
    last_d = last_q;    h_d = h_q;         n_d = n_q;         maxl_d = maxl_q;
    i_d = i_q;          best_d = best_q;   p_d = p_q;         bestp_d = bestp_q;
    hp_d = hp_q;        ha_d = ha_q;       lp_d = lp_q;       rm_d = rm_q;
    qt_d = qt_q;        k_d = k_q;         ov_d = ov_q;       ob_d = ob_q;
    ol_d = ol_q;        tl_d = tl_q;
    hs_we = 1'b0;
    hs_wdata = '0;

    i1 = i_q + LCW'(1);
    eq = (hs_rd == la_rd);
    cont = 1'b0;
    m = '0;
    nb = best_q;
    ml = '0;
    l8 = 8'(best_q) - 8'(MIN_MATCH);
    is_match = (best_q >= LCW'(MIN_MATCH));
    final_b = 1'b0;
    drop = '0;
    em1 = (emitted_q == LEN_MAX) ? emitted_q : emitted_q + LEN_W'(1);

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (la_we) begin
            cnt_d = cnt_q + LCW'(1);
            if (in_i.in_byte == MARK_BYTE) begin
              marks_d = marks_q + LCW'(1);
            end
          end
          last_d  = in_i.is_last;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cnt_q != '0 &&
            (last_q || cnt_q == LCW'(LOOKAHEAD) || marks_q != '0)) begin
          n_d     = '0;
          lp_d    = head_q;
          state_d = S_NRD;
        end else begin
          if (last_q) begin
            fill_d    = '0;
            wp_d      = '0;
            emitted_d = '0;
            last_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      S_NRD: begin
        state_d = S_NCMP;
      end
      S_NCMP: begin
        if (n_q == '0) begin
          h_d = la_rd;
        end
        if (la_rd == MARK_BYTE) begin
          state_d = S_SETUP;
        end else if (i1_eq_cnt(n_q, cnt_q)) begin
          n_d     = n_q + LCW'(1);
          state_d = S_SETUP;
        end else begin
          n_d     = n_q + LCW'(1);
          lp_d    = linc(lp_q);
          state_d = S_NRD;
        end
      end
      S_SETUP: begin
        ml = (FW'(n_q) < fill_q) ? FW'(n_q) : fill_q;
        maxl_d = LCW'(ml);
        best_d = '0;
        if (ml < FW'(MIN_MATCH)) begin
          k_d     = '0;
          state_d = S_EMIT;
        end else begin
          p_d     = '0;
          hp_d    = base;
          ha_d    = base;
          i_d     = '0;
          lp_d    = head_q;
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        state_d = S_HCMP;
      end
      S_HCMP: begin
        cont = eq && (i1 < maxl_q) && ((FW1'(p_q) + FW1'(i1)) < FW1'(fill_q));
        if (cont) begin
          i_d     = i1;
          ha_d    = hinc(ha_q);
          lp_d    = linc(lp_q);
          state_d = S_HRD;
        end else begin
          m = eq ? i1 : i_q;
          if (m > best_q) begin
            nb      = m;
            best_d  = m;
            bestp_d = p_q;
          end
          // Stop once the needle is fully matched or no start position is left.
          if (nb == maxl_q ||
              (FW1'(p_q) + FW1'(1 + MIN_MATCH)) > FW1'(fill_q)) begin
            if (nb >= LCW'(MIN_MATCH)) begin
              rm_d    = DW'(fill_q - ((m > best_q) ? p_q : bestp_q));
              qt_d    = '0;
              state_d = S_DIV;
            end else begin
              k_d     = '0;
              state_d = S_EMIT;
            end
          end else begin
            p_d     = p_q + FW'(1);
            hp_d    = hinc(hp_q);
            ha_d    = hinc(hp_q);
            i_d     = '0;
            lp_d    = head_q;
            state_d = S_HRD;
          end
        end
      end
      S_DIV: begin
        if (rm_q >= DW'(DIST_DIV)) begin
          rm_d = rm_q - DW'(DIST_DIV);
          qt_d = qt_q + 5'd1;
        end else begin
          k_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          if (!is_match) begin
            hs_wdata = h_q;
            final_b  = 1'b1;
            drop     = LCW'(1);
          end else begin
            case (k_q)
              2'd0:    hs_wdata = JUMP_BASE | ((l8 & 8'h18) >> 3);
              2'd1:    hs_wdata = ((l8 & 8'h07) << 5) | (8'(qt_q) & 8'h1F);
              default: hs_wdata = 8'(rm_q);
            endcase
            final_b = (k_q == 2'd2);
            drop    = best_q;
          end
          hs_we     = 1'b1;
          wp_d      = hinc(wp_q);
          fill_d    = (fill_q < FW'(WLIM)) ? fill_q + FW'(1) : fill_q;
          emitted_d = em1;
          ov_d      = 1'b1;
          ob_d      = hs_wdata;
          tl_d      = em1;
          ol_d      = final_b && last_q && (cnt_q == drop);
          k_d       = k_q + 2'd1;
          if (final_b) begin
            head_d = hadd(head_q, drop);
            cnt_d  = cnt_q - drop;
            if (!is_match && h_q == MARK_BYTE) begin
              marks_d = marks_q - LCW'(1);
            end
            state_d = S_CHECK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      wp_q      <= '0;
      head_q    <= '0;
      cnt_q     <= '0;
      marks_q   <= '0;
      emitted_q <= '0;
      last_q    <= 1'b0;
      ov_q      <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      wp_q      <= wp_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      marks_q   <= marks_d;
      emitted_q <= emitted_d;
      last_q    <= last_d;
      ov_q      <= ov_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    n_q     <= n_d;
    maxl_q  <= maxl_d;
    i_q     <= i_d;
    best_q  <= best_d;
    p_q     <= p_d;
    bestp_q <= bestp_d;
    hp_q    <= hp_d;
    ha_q    <= ha_d;
    lp_q    <= lp_d;
    rm_q    <= rm_d;
    qt_q    <= qt_d;
    ob_q    <= ob_d;
    ol_q    <= ol_d;
    tl_q    <= tl_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.out_last     = ol_q;
  assign out_o.total_length = tl_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LCW'(LOOKAHEAD)) else $error("lookahead count overflow");
  a_marks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marks_q <= cnt_q) else $error("mark count exceeds lookahead count");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WLIM)) else $error("history fill beyond window");
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_CHECK && ol_d) |=> (cnt_q == '0))
    else $error("last byte emitted with lookahead not empty");
`endif

endmodule

// ===== verif/tb_lz_window_text_compressor_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lz_window_text_compressor_core
// Self-checking bench for the LZ window compressor: drives byte blocks through
// the input channel, predicts every compressed byte with its own greedy
// matcher, and compares each output request field by field in order.
// ----------------------------------------------------------------------------
module tb_lz_window_text_compressor_core;
  import lzw_pkg::*;

  localparam int WINDOW        = 3792;
  localparam int LOOKAHEAD     = 35;
  localparam int HISTORY_DEPTH = 4096;
  localparam int N_RANDOM      = 117;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] total;
  } comp_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       check;
    logic [7:0] final_byte;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lzw_in_if  in_ch();
  lzw_out_if out_ch();

  lz_window_text_compressor_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  logic [7:0]       hist_mem [HISTORY_DEPTH];
  int               hist_fill;
  int               wr_ptr;
  logic [7:0]       pending [$];
  logic [LEN_W-1:0] out_count;
  comp_byte_t       expected_bytes [$];

  int errors;
  int n_items;
  int n_results;
  int n_blocks;
  int n_jumps;

  function automatic void emit_byte(logic [7:0] b);
    comp_byte_t c;
    int lim;
    lim = (WINDOW < HISTORY_DEPTH) ? WINDOW : HISTORY_DEPTH;
    hist_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1 >= HISTORY_DEPTH) ? 0 : wr_ptr + 1;
    if (hist_fill < lim) hist_fill++;
    if (out_count != LEN_MAX) out_count++;
    c.data  = b;
    c.last  = 1'b0;
    c.total = out_count;
    expected_bytes.push_back(c);
  endfunction

  function automatic logic [7:0] hist_byte(int w, int p);
    return hist_mem[(wr_ptr + HISTORY_DEPTH - w + p) % HISTORY_DEPTH];
  endfunction

  function automatic void encode_head();
    logic [7:0] h;
    int n, w, maxl, len, p, i, distance, j, l;
    bit found;
    h = pending[0];
    found = 1'b0;
    p = 0;
    if (h == MARK_BYTE) begin
      emit_byte(h);
      void'(pending.pop_front());
      return;
    end
    n = 0;
    while (n < pending.size() && n < LOOKAHEAD && pending[n] != MARK_BYTE) n++;
    w = hist_fill;
    maxl = (n < w) ? n : w;
    for (len = maxl; len >= MIN_MATCH && !found; len--) begin
      for (p = 0; p + len <= w; p++) begin
        for (i = 0; i < len; i++)
          if (hist_byte(w, p + i) != pending[i]) break;
        if (i == len) begin
          found = 1'b1;
          break;
        end
      end
      if (found) break;
    end
    if (found) begin
      distance = w - p;
      j = 256 * (distance / DIST_DIV) + distance % DIST_DIV;
      l = len - MIN_MATCH;
      emit_byte(JUMP_BASE | 8'((l & 'h18) >> 3));
      emit_byte(8'(((l & 'h07) << 5) | ((j & 'h1F00) >> 8)));
      emit_byte(8'(j & 'hFF));
      n_jumps++;
      for (i = 0; i < len; i++) void'(pending.pop_front());
    end else begin
      emit_byte(h);
      void'(pending.pop_front());
    end
  endfunction

  function automatic bit pending_has_mark();
    foreach (pending[k]) if (pending[k] == MARK_BYTE) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void compress_byte(logic [7:0] b, logic last);
    int first;
    first = expected_bytes.size();
    if (pending.size() < LOOKAHEAD) pending.push_back(b);
    if (last) begin
      while (pending.size() > 0) encode_head();
      if (expected_bytes.size() > first) expected_bytes[$].last = 1'b1;
      hist_fill = 0;
      wr_ptr = 0;
      out_count = '0;
      n_blocks++;
    end else begin
      while (pending.size() > 0 && (pending.size() >= LOOKAHEAD || pending_has_mark()))
        encode_head();
    end
  endfunction

  // Drives one request and updates the prediction when it is taken.
  task automatic send_byte(logic [7:0] b, logic last, bit quiet);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.is_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    compress_byte(b, last);
    n_items++;
  endtask

  // Output side: compare each taken request, then pick the next ready value.
  initial begin
    int stall;
    bit held;
    comp_byte_t exp_c;
    stall = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %0h", out_ch.out_byte);
          errors++;
        end else begin
          exp_c = expected_bytes.pop_front();
          if (out_ch.out_byte !== exp_c.data) begin
            $error("out_byte expected %0h actual %0h", exp_c.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.out_last !== exp_c.last) begin
            $error("out_last expected %0b actual %0b", exp_c.last, out_ch.out_last);
            errors++;
          end
          if (out_ch.total_length !== exp_c.total) begin
            $error("total_length expected %0d actual %0d", exp_c.total,
                   out_ch.total_length);
            errors++;
          end
        end
      end
      // A long hold-off once the random part is under way, so the input backs up.
      if (!held && n_items > 40) begin
        held = 1'b1;
        stall = 600;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ((n_results / 60) % 3 != 0 && $urandom_range(0, 4) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                              : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    logic [7:0] alpha [4];
    int blen, k, waited;
    bit quiet;
    logic [7:0] b, d;

    errors = 0; n_items = 0; n_results = 0; n_blocks = 0; n_jumps = 0;
    hist_fill = 0; wr_ptr = 0; out_count = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.is_last = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte blocks at the byte extremes and the marker value.
    rows.push_back('{8'h00, 1'b1, 1'b1, 8'h00});
    rows.push_back('{8'hFF, 1'b1, 1'b1, 8'hFF});
    rows.push_back('{8'hFE, 1'b1, 1'b1, 8'hFE});
    // A repeated four-byte string becomes a minimum-length jump at distance 4.
    rows.push_back('{8'h41, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h42, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h43, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h44, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h41, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h42, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h43, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h44, 1'b1, 1'b1, 8'h04});
    // Marker bytes cut the needle short and force early decisions.
    rows.push_back('{8'h61, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h62, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h63, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h64, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'hFE, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h61, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h62, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h63, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h64, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'hFE, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h61, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h62, 1'b1, 1'b0, 8'h00});

    foreach (rows[r]) begin
      send_byte(rows[r].data, rows[r].last, 1'b1);
      if (rows[r].check && expected_bytes[$].data !== rows[r].final_byte) begin
        $error("out_byte expected %0h predicted %0h", rows[r].final_byte,
               expected_bytes[$].data);
        errors++;
      end
    end

    // Random blocks: a small alphabet breeds matches, with markers and
    // full-range bytes mixed in; a few blocks run past the lookahead length.
    k = 0;
    while (k < N_RANDOM) begin
      foreach (alpha[a]) alpha[a] = 8'($urandom);
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(36, 70) : $urandom_range(1, 24);
      if (blen > N_RANDOM - k) blen = N_RANDOM - k;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < blen; i++) begin
        d = 8'($urandom_range(0, 9));
        if (d < 6)       b = alpha[$urandom_range(0, 3)];
        else if (d == 6) b = MARK_BYTE;
        else             b = 8'($urandom);
        send_byte(b, i == blen - 1, quiet);
        k++;
      end
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (expected_bytes.size() != 0 && waited < 2000000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected output bytes never arrived", expected_bytes.size());
      errors++;
    end

    $display("Covered %0d input bytes in %0d blocks, %0d output bytes, %0d jump codes.",
             n_items, n_blocks, n_results, n_jumps);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
